/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the trig polynomial block.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SCTP_ASSERT_IMPLIES(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define SCTP_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SCTP_ASSERT_IMPLIES(lbl, clk, rstn, prop)
`define SCTP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/core/sctp_pkg.sv */
// Types, fixed-point formats and constants of the sine/cosine/tangent block.
// No dependencies.
package sctp_pkg;

    localparam int ANGLE_FRAC_BITS    = 16;
    localparam int RESULT_FRAC_BITS   = 16;
    localparam int INTERNAL_FRAC_BITS = 30;
    localparam int COEF_BITS          = 58;
    localparam int NTERMS             = 8;

    localparam int XW     = 34;                       // reduced angle, signed
    localparam int X2W    = 34;                       // its square, unsigned
    localparam int ACC_W  = 64;                       // Horner sums
    localparam int SCW    = 34;                       // sine/cosine, signed
    localparam int DC_W   = 32;                       // divisor magnitude
    localparam int DIV_W  = DC_W + RESULT_FRAC_BITS + 1;

    localparam logic [1:0] OP_SIN = 2'd0;
    localparam logic [1:0] OP_COS = 2'd1;
    localparam logic [1:0] OP_TAN = 2'd2;

    localparam int CINV_FB = 64 - ANGLE_FRAC_BITS;
    localparam logic [127:0] DEC_DEN = 128'd10000000;
    localparam logic [127:0] CINV_W  =
        ((128'd1591549 << CINV_FB) + DEC_DEN / 128'd2) / DEC_DEN;
    localparam logic [63:0] CINV = CINV_W[63:0];
    localparam logic [127:0] TP_W = (128'd6 << INTERNAL_FRAC_BITS) +
        ((128'd2831852 << INTERNAL_FRAC_BITS) + DEC_DEN / 128'd2) / DEC_DEN;
    localparam logic [127:0] PI_W = (128'd3 << INTERNAL_FRAC_BITS) +
        ((128'd1415926 << INTERNAL_FRAC_BITS) + DEC_DEN / 128'd2) / DEC_DEN;
    localparam logic [32:0] TP = TP_W[32:0];
    localparam logic [31:0] PI = PI_W[31:0];

    localparam logic [63:0] P58 = 64'd1 << COEF_BITS;

    localparam logic signed [63:0] SIN_COEF [0:NTERMS] = '{
        $signed(P58),
        -$signed((P58 + 64'd3) / 64'd6),
        $signed((P58 + 64'd60) / 64'd120),
        -$signed((P58 + 64'd2520) / 64'd5040),
        $signed((P58 + 64'd181440) / 64'd362880),
        -$signed((P58 + 64'd19958400) / 64'd39916800),
        $signed((P58 + 64'd3113510400) / 64'd6227020800),
        -$signed((P58 + 64'd653837139968) / 64'd1307674279936),
        $signed((P58 + 64'd177843707314176) / 64'd355687414628352)
    };

    localparam logic signed [63:0] COS_COEF [0:NTERMS] = '{
        $signed(P58),
        -$signed((P58 + 64'd1) / 64'd2),
        $signed((P58 + 64'd12) / 64'd24),
        -$signed((P58 + 64'd360) / 64'd720),
        $signed((P58 + 64'd20160) / 64'd40320),
        -$signed((P58 + 64'd1814400) / 64'd3628800),
        $signed((P58 + 64'd239500800) / 64'd479001600),
        -$signed((P58 + 64'd43589144576) / 64'd87178289152),
        $signed((P58 + 64'd10461394239488) / 64'd20922788478976)
    };

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] angle;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic                    vld;
        logic [1:0]              op;
        logic signed [XW-1:0]    x;
        logic [X2W-1:0]          x2;
        logic signed [ACC_W-1:0] acc_s;
        logic signed [ACC_W-1:0] acc_c;
    } t_hrn_word;

    typedef struct packed {
        logic             vld;
        logic [1:0]       op;
        logic             neg;
        logic             czero;
        logic [31:0]      res01;
        logic [DC_W-1:0]  dc;
        logic [DIV_W-1:0] num;
        logic [DC_W-1:0]  rem;
        logic [DIV_W-1:0] quo;
    } t_div_word;

endpackage

/* rtl/core/sctp_reduce.sv */
// Range reduction of the angle to [-pi, pi) and its square, four stages.
// Depends on sctp_pkg.
module sctp_reduce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  sctp_pkg::t_in_word   i_word,
    output sctp_pkg::t_hrn_word  o_word
);

    localparam int F = sctp_pkg::INTERNAL_FRAC_BITS;

    logic                  r_a_vld;
    logic [1:0]            r_a_op;
    logic signed [64:0]    r_a_plo, r_a_phi;
    logic signed [64:0]    n_a_plo, n_a_phi;

    logic                  r_b_vld;
    logic [1:0]            r_b_op;
    logic [62:0]           r_b_tprod;
    logic [63:0]           w_ph;
    logic [F-1:0]          w_ix;

    logic                  r_c_vld;
    logic [1:0]            r_c_op;
    logic signed [sctp_pkg::XW-1:0] r_c_x;
    logic [63:0]           w_xr;
    logic [sctp_pkg::XW-1:0] w_xu;

    logic [sctp_pkg::XW-1:0] w_xm;
    logic [63:0]           w_sq;
    logic [64:0]           w_sqr;
    sctp_pkg::t_hrn_word   r_d;

    // stage A: angle times 1/(2 pi), split over two 32-bit partial products
    assign n_a_plo = i_word.angle * $signed({1'b0, sctp_pkg::CINV[31:0]});
    assign n_a_phi = i_word.angle * $signed({1'b0, sctp_pkg::CINV[63:32]});

    // stage B: fraction of a turn plus one half, then scale by 2 pi
    assign w_ph = r_a_plo[63:0] + {r_a_phi[31:0], 32'd0} + {1'b1, 63'd0};
    assign w_ix = w_ph[63:64-F];

    // stage C: round and take away pi
    assign w_xr = {1'b0, r_b_tprod} + (64'd1 << (F - 1));
    assign w_xu = w_xr[F+sctp_pkg::XW-1:F];

    // stage D: square
    assign w_xm  = r_c_x[sctp_pkg::XW-1] ? -r_c_x : r_c_x;
    assign w_sq  = 64'(w_xm[31:0]) * 64'(w_xm[31:0]);
    assign w_sqr = {1'b0, w_sq} + (65'd1 << (F - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld   <= i_vld;
            r_a_op    <= i_word.opcode;
            r_a_plo   <= n_a_plo;
            r_a_phi   <= n_a_phi;
            r_b_vld   <= r_a_vld;
            r_b_op    <= r_a_op;
            r_b_tprod <= 63'(w_ix) * 63'(sctp_pkg::TP);
            r_c_vld   <= r_b_vld;
            r_c_op    <= r_b_op;
            r_c_x     <= $signed(w_xu - sctp_pkg::XW'(sctp_pkg::PI));
            r_d.vld   <= r_c_vld;
            r_d.op    <= r_c_op;
            r_d.x     <= r_c_x;
            r_d.x2    <= w_sqr[F+sctp_pkg::X2W-1:F];
            r_d.acc_s <= sctp_pkg::SIN_COEF[sctp_pkg::NTERMS];
            r_d.acc_c <= sctp_pkg::COS_COEF[sctp_pkg::NTERMS];
        end
    end

    assign o_word = r_d;

endmodule

/* rtl/core/sctp_hrn_cell.sv */
// One Horner step for both the sine and cosine lanes, two register stages.
// Depends on sctp_pkg.
module sctp_hrn_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic signed [63:0]         i_coef_s,
    input  logic signed [63:0]         i_coef_c,
    input  sctp_pkg::t_hrn_word        i_word,
    output sctp_pkg::t_hrn_word        o_word
);

    localparam int F  = sctp_pkg::INTERNAL_FRAC_BITS;
    localparam int PW = 32 + sctp_pkg::X2W;

    typedef struct packed {
        logic                          vld;
        logic [1:0]                    op;
        logic signed [sctp_pkg::XW-1:0] x;
        logic [sctp_pkg::X2W-1:0]      x2;
        logic                          neg_s;
        logic                          neg_c;
        logic [PW-1:0]                 ps_lo;
        logic [PW-1:0]                 ps_hi;
        logic [PW-1:0]                 pc_lo;
        logic [PW-1:0]                 pc_hi;
    } t_mid;

    logic [63:0]     w_mag_s, w_mag_c;
    t_mid            r_mid, n_mid;
    logic [PW+31:0]  w_sum_s, w_sum_c;
    logic [63:0]     w_sh_s, w_sh_c;
    sctp_pkg::t_hrn_word r_out, n_out;

    assign w_mag_s = i_word.acc_s[63] ? -i_word.acc_s : i_word.acc_s;
    assign w_mag_c = i_word.acc_c[63] ? -i_word.acc_c : i_word.acc_c;

    always_comb begin
        n_mid.vld   = i_word.vld;
        n_mid.op    = i_word.op;
        n_mid.x     = i_word.x;
        n_mid.x2    = i_word.x2;
        n_mid.neg_s = i_word.acc_s[63];
        n_mid.neg_c = i_word.acc_c[63];
        n_mid.ps_lo = PW'(w_mag_s[31:0]) * PW'(i_word.x2);
        n_mid.ps_hi = PW'(w_mag_s[63:32]) * PW'(i_word.x2);
        n_mid.pc_lo = PW'(w_mag_c[31:0]) * PW'(i_word.x2);
        n_mid.pc_hi = PW'(w_mag_c[63:32]) * PW'(i_word.x2);
    end

    // combine partial products, round, restore sign, add coefficient
    assign w_sum_s = (PW+32)'(r_mid.ps_lo) + {r_mid.ps_hi, 32'd0} + ((PW+32)'(1) << (F - 1));
    assign w_sum_c = (PW+32)'(r_mid.pc_lo) + {r_mid.pc_hi, 32'd0} + ((PW+32)'(1) << (F - 1));
    assign w_sh_s  = w_sum_s[F+63:F];
    assign w_sh_c  = w_sum_c[F+63:F];

    always_comb begin
        n_out.vld   = r_mid.vld;
        n_out.op    = r_mid.op;
        n_out.x     = r_mid.x;
        n_out.x2    = r_mid.x2;
        n_out.acc_s = i_coef_s + $signed(r_mid.neg_s ? -w_sh_s : w_sh_s);
        n_out.acc_c = i_coef_c + $signed(r_mid.neg_c ? -w_sh_c : w_sh_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.vld <= 1'b0;
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_mid <= n_mid;
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

/* rtl/core/sctp_div_cell.sv */
// One restoring-division step: bring down a numerator bit, make one quotient bit.
// Depends on sctp_pkg.
module sctp_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  sctp_pkg::t_div_word  i_word,
    output sctp_pkg::t_div_word  o_word
);

    localparam int DW = sctp_pkg::DC_W;
    localparam int NW = sctp_pkg::DIV_W;

    logic [DW:0]         w_r2;
    logic [DW:0]         w_diff;
    logic                w_ge;
    sctp_pkg::t_div_word r_word, n_word;

    assign w_r2   = {i_word.rem, i_word.num[NW-1]};
    assign w_diff = w_r2 - {1'b0, i_word.dc};
    assign w_ge   = (w_r2 >= {1'b0, i_word.dc});

    always_comb begin
        n_word     = i_word;
        n_word.rem = w_ge ? w_diff[DW-1:0] : w_r2[DW-1:0];
        n_word.num = {i_word.num[NW-2:0], 1'b0};
        n_word.quo = {i_word.quo[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/core/sine_cosine_tangent_polynomial.sv */
// Top level of the sine/cosine/tangent polynomial block.
// Depends on sctp_pkg, sctp_reduce, sctp_hrn_cell, sctp_div_cell, assert_macros.svh.
//
// Use:
//   Input channel i_valid/o_ready/i_data carries one word per item: an opcode
//   (sine, cosine, tangent) and a signed Q16.16 angle in radians. Output channel
//   o_valid/i_ready/o_data carries one word per item: a signed Q16.16 result and
//   a saturated flag, set only when a tangent overflows or its cosine is zero.
//   An unused opcode gives zero, not saturated.
// Timing:
//   Every word goes down a fixed pipeline: 4 reduction stages, 8 Horner cells of
//   2 stages each, 3 stages forming sine, cosine and the divider operands, 49
//   restoring-division cells and one output register. One word per cycle is
//   taken and delivered when i_ready stays high. The division chain (one
//   quotient bit per cell) sets the depth.
// Stall:
//   The whole chain advances on one enable: it moves whenever the output
//   register is empty or being taken. A held output freezes every stage and
//   drops o_ready; nothing is lost.
// Reset:
//   Synchronous, active low; clears all stage valid bits so the pipe is empty.
`include "assert_macros.svh"

module sine_cosine_tangent_polynomial (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sctp_pkg::t_in_word    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sctp_pkg::t_out_word   o_data
);

    localparam int F   = sctp_pkg::INTERNAL_FRAC_BITS;
    localparam int CB  = sctp_pkg::COEF_BITS;
    localparam int RF  = sctp_pkg::RESULT_FRAC_BITS;
    localparam int NT  = sctp_pkg::NTERMS;
    localparam int NW  = sctp_pkg::DIV_W;
    localparam int SCW = sctp_pkg::SCW;

    // sine product stage
    typedef struct packed {
        logic              vld;
        logic [1:0]        op;
        logic              neg;
        logic [63:0]       plo;
        logic [63:0]       phi;
        logic signed [63:0] hc;
    } t_s1;

    // sine and cosine at internal precision
    typedef struct packed {
        logic                  vld;
        logic [1:0]            op;
        logic signed [SCW-1:0] s;
        logic signed [SCW-1:0] c;
    } t_s2;

    logic                 w_en;
    sctp_pkg::t_hrn_word  w_hrn [0:NT];
    sctp_pkg::t_div_word  w_div [0:NW];

    // stage S1 signals
    logic [31:0]          w_xm;
    logic [63:0]          w_hm;
    t_s1                  r_s1, n_s1;

    // stage S2 signals
    logic [95:0]          w_ssum;
    logic [95-CB:0]       w_smag;
    logic [63:0]          w_cm;
    logic [64:0]          w_cr;
    logic [64-(CB-F):0]   w_cmag;
    t_s2                  r_s2, n_s2;

    // stage S3 signals
    logic [SCW-1:0]       w_sa, w_ca;
    logic [SCW:0]         w_sr, w_cr2;
    logic [SCW-1:0]       w_sres, w_cres;
    logic [31:0]          w_res01;
    sctp_pkg::t_div_word  r_s3, n_s3;

    // output stage signals
    logic [NW:0]          w_qr;
    logic [NW:0]          w_lim;
    logic                 w_sat;
    sctp_pkg::t_out_word  n_out;
    sctp_pkg::t_out_word  r_out;
    logic                 r_out_vld;

    // assertion terms
    logic                 w_sat_out;
    logic                 w_clamp_val;
    logic                 w_bad_sat;

    // advance the whole chain unless a held result blocks the output register
    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    sctp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_word  (i_data),
        .o_word  (w_hrn[0])
    );

    // Horner chain: cell i adds coefficient NT-1-i
    for (genvar gi = 0; gi < NT; gi++) begin : g_hrn
        sctp_hrn_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_coef_s (sctp_pkg::SIN_COEF[NT-1-gi]),
            .i_coef_c (sctp_pkg::COS_COEF[NT-1-gi]),
            .i_word   (w_hrn[gi]),
            .o_word   (w_hrn[gi+1])
        );
    end

    // S1: sine = x times the sine sum, split into two 32x32 products
    assign w_xm = 32'(w_hrn[NT].x[sctp_pkg::XW-1] ? -w_hrn[NT].x : w_hrn[NT].x);
    assign w_hm = w_hrn[NT].acc_s[63] ? -w_hrn[NT].acc_s : w_hrn[NT].acc_s;

    always_comb begin
        n_s1.vld = w_hrn[NT].vld;
        n_s1.op  = w_hrn[NT].op;
        n_s1.neg = w_hrn[NT].x[sctp_pkg::XW-1] != w_hrn[NT].acc_s[63];
        n_s1.plo = 64'(w_xm) * 64'(w_hm[31:0]);
        n_s1.phi = 64'(w_xm) * 64'(w_hm[63:32]);
        n_s1.hc  = w_hrn[NT].acc_c;
    end

    // S2: round sine product and cosine sum to internal precision
    assign w_ssum = {32'd0, r_s1.plo} + {r_s1.phi, 32'd0} + (96'd1 << (CB - 1));
    assign w_smag = w_ssum[95:CB];
    assign w_cm   = r_s1.hc[63] ? -r_s1.hc : r_s1.hc;
    assign w_cr   = {1'b0, w_cm} + (65'd1 << (CB - F - 1));
    assign w_cmag = w_cr[64:CB-F];

    always_comb begin
        n_s2.vld = r_s1.vld;
        n_s2.op  = r_s1.op;
        n_s2.s   = $signed(r_s1.neg ? -SCW'(w_smag) : SCW'(w_smag));
        n_s2.c   = $signed(r_s1.hc[63] ? -SCW'(w_cmag) : SCW'(w_cmag));
    end

    // S3: results for sine/cosine, and divider operands for tangent
    assign w_sa   = r_s2.s[SCW-1] ? -r_s2.s : r_s2.s;
    assign w_ca   = r_s2.c[SCW-1] ? -r_s2.c : r_s2.c;
    assign w_sr   = ({1'b0, w_sa} + ((SCW+1)'(1) << (F - RF - 1))) >> (F - RF);
    assign w_cr2  = ({1'b0, w_ca} + ((SCW+1)'(1) << (F - RF - 1))) >> (F - RF);
    assign w_sres = r_s2.s[SCW-1] ? -w_sr[SCW-1:0] : w_sr[SCW-1:0];
    assign w_cres = r_s2.c[SCW-1] ? -w_cr2[SCW-1:0] : w_cr2[SCW-1:0];

    always_comb begin
        case (r_s2.op)
            sctp_pkg::OP_SIN: w_res01 = w_sres[31:0];
            sctp_pkg::OP_COS: w_res01 = w_cres[31:0];
            default:          w_res01 = 32'd0;
        endcase
    end

    always_comb begin
        n_s3.vld   = r_s2.vld;
        n_s3.op    = r_s2.op;
        n_s3.czero = (r_s2.c == '0);
        n_s3.neg   = n_s3.czero ? r_s2.s[SCW-1] : (r_s2.s[SCW-1] != r_s2.c[SCW-1]);
        n_s3.res01 = w_res01;
        n_s3.dc    = w_ca[sctp_pkg::DC_W-1:0];
        n_s3.num   = {w_sa[sctp_pkg::DC_W-1:0], (RF + 1)'(0)};
        n_s3.rem   = '0;
        n_s3.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
        end else if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign w_div[0] = r_s3;

    // division chain: one quotient bit per cell, most significant first
    for (genvar gd = 0; gd < NW; gd++) begin : g_div
        sctp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_div[gd]),
            .o_word  (w_div[gd+1])
        );
    end

    // output: round the quotient by its spare bit, then clamp to Q16.16
    assign w_qr  = ({1'b0, w_div[NW].quo} + (NW+1)'(1)) >> 1;
    assign w_lim = w_div[NW].neg ? ((NW+1)'(1) << 31) : (((NW+1)'(1) << 31) - (NW+1)'(1));
    assign w_sat = w_div[NW].czero || (w_qr > w_lim);

    always_comb begin
        n_out.result    = $signed(w_div[NW].res01);
        n_out.saturated = 1'b0;
        if (w_div[NW].op == sctp_pkg::OP_TAN) begin
            n_out.saturated = w_sat;
            if (w_sat) begin
                n_out.result = w_div[NW].neg ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
            end else begin
                n_out.result = $signed(w_div[NW].neg ? -w_qr[31:0] : w_qr[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div[NW].vld;
            r_out     <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    assign w_sat_out   = o_valid && o_data.saturated;
    assign w_clamp_val = (o_data.result == 32'h7FFF_FFFF) || (o_data.result == 32'h8000_0000);
    assign w_bad_sat   = w_div[NW].vld && n_out.saturated && (w_div[NW].op != sctp_pkg::OP_TAN);

    // a saturated word always carries one of the two clamp values
    `SCTP_ASSERT_IMPLIES(a_sat_clamp, i_clk, i_rst_n, w_sat_out |-> w_clamp_val)
    // a held output freezes the divider operand stage
    `SCTP_ASSERT_IMPLIES(a_stall_hold, i_clk, i_rst_n, (!o_ready) |=> $stable(r_s3))
    // only tangent words may reach the output saturated
    `SCTP_ASSERT_NEVER(a_sat_op, i_clk, i_rst_n, w_en && w_bad_sat)

endmodule

/* verif/sctp_checker.sv */
// Checker for the sine/cosine/tangent block: watches both channels, predicts each result
// word from the accepted input word and compares them field by field.
// Depends on sctp_pkg.
module sctp_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready_dut,
    input  sctp_pkg::t_in_word  i_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  sctp_pkg::t_out_word i_out_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_words_in,
    output int                  o_words_out
);
    import sctp_pkg::*;

    localparam int FB = INTERNAL_FRAC_BITS;

    t_out_word trig_expected_q[$];

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Unsigned product, rounded shift right, kept to 64 bits.
    function automatic logic [63:0] umul_rnd(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        return p[127:0] >> s;
    endfunction

    function automatic logic signed [63:0] smul_rnd(logic signed [63:0] a,
                                                   logic signed [63:0] b, int s);
        logic [63:0] m;
        m = umul_rnd(mag64(a), mag64(b), s);
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] narrow(logic signed [63:0] v, int s);
        logic [63:0] m;
        if (s == 0) return v;
        m = (mag64(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    // Alternating series in x2 with factorial divisors, 58 fraction bits.
    function automatic logic signed [63:0] series(bit odd, logic signed [63:0] x2);
        logic [63:0] divs [0:7];
        logic signed [63:0] acc, c;
        logic [63:0] d;
        if (odd)
            divs = '{64'd6, 64'd120, 64'd5040, 64'd362880, 64'd39916800,
                     64'd6227020800, 64'd1307674279936, 64'd355687414628352};
        else
            divs = '{64'd2, 64'd24, 64'd720, 64'd40320, 64'd3628800,
                     64'd479001600, 64'd87178289152, 64'd20922788478976};
        acc = 0;
        for (int k = 8; k >= 0; k--) begin
            if (k == 0) begin
                c = 64'sd1 <<< 58;
            end else begin
                d = divs[k - 1];
                c = $signed(((64'd1 << 58) + d / 2) / d);
                if (k % 2 == 1) c = -c;
            end
            acc = (k == 8) ? c : c + smul_rnd(acc, x2, FB);
        end
        return acc;
    endfunction

    function automatic t_out_word trig_predict(t_in_word w);
        t_out_word r;
        logic [63:0] au, ph, ix, ns, dc, q, rm, lim;
        logic signed [63:0] x, x2, sn, cs;
        bit sat, neg;
        au = {{32{w.angle[31]}}, w.angle};
        ph = au * CINV + (64'd1 << 63);
        ix = ph >> (64 - FB);
        x  = $signed(umul_rnd(ix, {31'd0, TP}, FB)) - $signed({32'd0, PI});
        x2 = smul_rnd(x, x, FB);
        sn = smul_rnd(x, series(1'b1, x2), COEF_BITS);
        cs = narrow(series(1'b0, x2), COEF_BITS - FB);
        r = '0;
        case (w.opcode)
            OP_SIN: r.result = narrow(sn, FB - RESULT_FRAC_BITS);
            OP_COS: r.result = narrow(cs, FB - RESULT_FRAC_BITS);
            OP_TAN: begin
                sat = 0;
                neg = (sn < 0) != (cs < 0);
                if (cs == 0) begin
                    sat = 1;
                    neg = sn < 0;
                end else begin
                    ns = mag64(sn);
                    dc = mag64(cs);
                    q = ns / dc;
                    rm = ns % dc;
                    for (int i = 0; i < RESULT_FRAC_BITS + 1 && !sat; i++) begin
                        rm = rm << 1;
                        q = q << 1;
                        if (rm >= dc) begin
                            rm = rm - dc;
                            q = q | 64'd1;
                        end
                        if (q > (64'd1 << 34)) sat = 1;
                    end
                    if (!sat) begin
                        q = (q + 1) >> 1;
                        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                        if (q > lim) sat = 1;
                        else r.result = neg ? -q[31:0] : q[31:0];
                    end
                end
                if (sat) r.result = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r.saturated = sat;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            o_errors    <= 0;
            o_pending   <= 0;
            o_words_in  <= 0;
            o_words_out <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_words_out <= o_words_out + 1;
                if (trig_expected_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result word %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = trig_expected_q.pop_front();
                    if (want.result !== i_out_data.result ||
                        want.saturated !== i_out_data.saturated) begin
                        if (o_errors < 10)
                            $display("mismatch: expected result %h sat %b, got %h sat %b",
                                     want.result, want.saturated,
                                     i_out_data.result, i_out_data.saturated);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_dut) begin
                o_words_in <= o_words_in + 1;
                trig_expected_q.push_back(trig_predict(i_data));
            end
            o_pending <= trig_expected_q.size();
        end
    end
endmodule

/* verif/tb.sv */
// Testbench top for sine_cosine_tangent_polynomial: drives angle words with random
// gaps and output stalls, and reports the verdict from sctp_checker. Depends on sctp_pkg.
module tb;
    import sctp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_word o_data;

    int errors, pending, words_in, words_out;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int sent = 0;

    sine_cosine_tangent_polynomial dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data
    );

    sctp_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_dut(o_ready), .i_data,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .o_errors(errors), .o_pending(pending), .o_words_in(words_in),
        .o_words_out(words_out)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Receiver: random stalls, plus a long hold-off on request so the pipe fills.
    initial begin
        int holds_done, hold_left;
        holds_done = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: count cycles where no word moves on either channel.
    initial begin
        int idle, last_in, last_out;
        idle = 0;
        last_in = 0;
        last_out = 0;
        forever begin
            @(negedge i_clk);
            if (words_in != last_in || words_out != last_out) idle = 0;
            else idle++;
            last_in = words_in;
            last_out = words_out;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("sine_cosine_tangent_polynomial verification failed");
                $finish;
            end
        end
    end

    // Offer one word; hold valid and payload until the checker counts it accepted.
    task automatic send_angle(logic [1:0] op, logic [31:0] ang);
        t_in_word w;
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        w.opcode = op;
        w.angle = ang;
        i_valid <= 1;
        i_data <= w;
        sent++;
        do @(negedge i_clk); while (words_in < sent);
    endtask

    task automatic drain_results();
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic random_angles(int n);
        logic [1:0] op;
        logic [31:0] ang;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            case ($urandom_range(3))
                0: ang = $urandom;
                1: ang = 32'($signed($urandom_range(2 * 411775)) - 411775);
                2: ang = 32'($signed($urandom_range(2000)) - 1000 + 102944 *
                         ($urandom_range(1) ? 1 : -1));
                default: ang = 32'($signed($urandom_range(131072)) - 65536);
            endcase
            send_angle(op, ang);
        end
    endtask

    initial begin
        logic [31:0] corner [0:5];
        corner = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd102944,
                   -32'sd102944, 32'd205887};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: range ends, quarter turns near a zero cosine, every opcode.
        foreach (corner[k])
            for (int op = 0; op < 4; op++)
                send_angle(2'(op), corner[k]);
        drain_results();

        tx_idle_pct = 27;
        rx_idle_pct = 50;
        random_angles(330);

        // Fill the pipe against a held output, then pause until it empties.
        hold_requests = 1;
        random_angles(120);
        drain_results();

        tx_idle_pct = 50;
        rx_idle_pct = 27;
        random_angles(300);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_angles(280);

        drain_results();
        if (errors == 0)
            $display("sine_cosine_tangent_polynomial verification clean");
        else
            $display("sine_cosine_tangent_polynomial verification failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sctp_pkg.sv
rtl/core/sctp_reduce.sv
rtl/core/sctp_hrn_cell.sv
rtl/core/sctp_div_cell.sv
rtl/core/sine_cosine_tangent_polynomial.sv
verif/sctp_checker.sv
verif/tb.sv
